FILE: hw/rtl/lptw_pkg.sv
// Package for the lidar polar-to-world transform: register indexes, fixed-point
// constants, default parameters and the CORDIC arctangent table.
// No dependencies.
package lptw_pkg;

   localparam int MAX_BEAMS           = 1024;
   localparam int ANGLE_BITS_DEF      = 16;
   localparam int ROTATION_STAGES_DEF = 16;

   localparam int RANGE_W = 16;
   localparam int BEAM_W  = 10;
   localparam int COORD_W = 32;
   localparam int HEAD_W  = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // CORDIC datapath width: range times gain compensation, plus growth and sign
   localparam int CORDIC_W = 35;

   localparam logic [RANGE_W-1:0] GAIN_INV     = 16'd39797;
   localparam logic [COORD_W-1:0] SENTINEL_POS = 32'd10238976;
   localparam logic [HEAD_W-1:0]  ANGLE_BIAS   = 16'hC000;
   localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_POSE_X        = 4'd0,
      REG_POSE_Y        = 4'd1,
      REG_POSE_HEADING  = 4'd2,
      REG_SHIFT_X       = 4'd3,
      REG_SHIFT_Y       = 4'd4,
      REG_SHIFT_HEADING = 4'd5,
      REG_BEAM_STEP     = 4'd6,
      REG_MAX_RANGE     = 4'd7
   } csr_reg_type;

   // atan(2^-i) in units of 2^-24 turn
   localparam logic [23:0] ATAN_TURNS24 [24] = '{
      24'd2097152, 24'd1238021, 24'd654136, 24'd332050,
      24'd166669,  24'd83416,   24'd41718,  24'd20860,
      24'd10430,   24'd5215,    24'd2608,   24'd1304,
      24'd652,     24'd326,     24'd163,    24'd81,
      24'd41,      24'd20,      24'd10,     24'd5,
      24'd3,       24'd1,       24'd1,      24'd0
   };

   // stage rotation angle rounded half up to angle_bits
   function automatic logic [23:0] stage_angle(input int i, input int angle_bits);
      int          s;
      logic [24:0] half;
      logic [24:0] sum;
      s    = 24 - angle_bits;
      half = (s > 0) ? (25'd1 << (s - 1)) : 25'd0;
      sum  = {1'b0, ATAN_TURNS24[i & 23]} + half;
      return 24'(sum >> s);
   endfunction

endpackage

FILE: hw/rtl/lidar_polar_to_world.sv
// Lidar beam to world point: angle build, pipelined CORDIC rotation, quadrant
// fix-up, rounding and pose offset, with an output register and skid stage.
// Depends on lptw_pkg.
//
//  channel | ports                                  | item
//  --------+----------------------------------------+----------------------------------
//  req     | req_tvalid req_tready req_tdata        | range_sample, beam_index
//  rsp     | rsp_tvalid rsp_tready rsp_tdata tuser  | world_x, world_y, beyond_range
//  csr     | csr_valid csr_ready csr_index csr_data | register write, always ready
//
// One item per cycle enters while req_tready is high; there is one register stage
// per CORDIC rotation plus multiply, angle, round and output stages.
// Reset clears all valid bits and loads register defaults (max_range all ones).
// A stalled output parks one item in the skid stage; req_tready drops only then.
module lidar_polar_to_world
   import lptw_pkg::*;
#(
   parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
   parameter int ROTATION_STAGES = ROTATION_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // range_sample[15:0], beam_index[25:16], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // world_x[31:0], world_y[63:32]
   output logic [0:0]            rsp_tuser,   // beyond_range[0]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ZW = ANGLE_BITS + 1;
   localparam int R  = ROTATION_STAGES;
   localparam logic [BEAM_W-1:0] BEAM_MASK =
      (MAX_BEAMS >= (1 << BEAM_W)) ? {BEAM_W{1'b1}} : BEAM_W'(MAX_BEAMS - 1);

   // configuration registers
   logic [COORD_W-1:0] pose_x_ff, pose_y_ff, shift_x_ff, shift_y_ff;
   logic [HEAD_W-1:0]  pose_heading_ff, shift_heading_ff, beam_step_ff;
   logic [RANGE_W-1:0] max_range_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_x_ff        <= '0;
         pose_y_ff        <= '0;
         pose_heading_ff  <= '0;
         shift_x_ff       <= '0;
         shift_y_ff       <= '0;
         shift_heading_ff <= '0;
         beam_step_ff     <= '0;
         max_range_ff     <= MAX_RANGE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            REG_POSE_X:        pose_x_ff        <= csr_data;
            REG_POSE_Y:        pose_y_ff        <= csr_data;
            REG_POSE_HEADING:  pose_heading_ff  <= csr_data[HEAD_W-1:0];
            REG_SHIFT_X:       shift_x_ff       <= csr_data;
            REG_SHIFT_Y:       shift_y_ff       <= csr_data;
            REG_SHIFT_HEADING: shift_heading_ff <= csr_data[HEAD_W-1:0];
            REG_BEAM_STEP:     beam_step_ff     <= csr_data[HEAD_W-1:0];
            REG_MAX_RANGE:     max_range_ff     <= csr_data[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   logic skid_v_ff;
   logic adv;

   assign adv        = !skid_v_ff;
   assign req_tready = adv;

   // stage A: multiplies and range check
   logic [RANGE_W-1:0]  rng;
   logic [BEAM_W-1:0]   idx;
   logic [25:0]         prod_in;
   logic [31:0]         gain_in;
   logic                a_v_ff, a_bey_ff;
   logic [HEAD_W-1:0]   a_prod_ff;
   logic [31:0]         a_x_ff;

   assign rng     = req_tdata[RANGE_W-1:0];
   assign idx     = req_tdata[RANGE_W +: BEAM_W] & BEAM_MASK;
   assign prod_in = 26'(idx) * 26'(beam_step_ff);
   assign gain_in = 32'(rng) * 32'(GAIN_INV);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_prod_ff <= prod_in[HEAD_W-1:0];
         a_x_ff    <= gain_in;
         a_bey_ff  <= (rng >= max_range_ff);
      end
   end

   // stage B: beam angle, quadrant and residual
   logic [HEAD_W-1:0]     a16_in;
   logic [ANGLE_BITS-1:0] ang_in;

   assign a16_in = ANGLE_BIAS + a_prod_ff + pose_heading_ff + shift_heading_ff;

   generate
      if (ANGLE_BITS >= HEAD_W) begin : g_widen
         assign ang_in =
            ANGLE_BITS'({a16_in, {(ANGLE_BITS - HEAD_W + 1){1'b0}}} >> 1);
      end else begin : g_trunc
         assign ang_in = a16_in[HEAD_W-1 -: ANGLE_BITS];
      end
   endgenerate

   logic                        v_ff   [R+1];
   logic                        bey_ff [R+1];
   logic [1:0]                  quad_ff[R+1];
   logic signed [CORDIC_W-1:0]  x_ff   [R+1];
   logic signed [CORDIC_W-1:0]  y_ff   [R+1];
   logic signed [ZW-1:0]        z_ff   [R+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bey_ff[0]  <= a_bey_ff;
         quad_ff[0] <= ang_in[ANGLE_BITS-1 -: 2];
         x_ff[0]    <= CORDIC_W'(a_x_ff);
         y_ff[0]    <= '0;
         z_ff[0]    <= ZW'(ang_in[ANGLE_BITS-3:0]);
      end
   end

   // CORDIC rotation stages
   generate
      for (genvar i = 0; i < R; i++) begin : g_rot
         localparam logic [ZW-1:0] DA = ZW'(stage_angle(i, ANGLE_BITS));
         logic signed [CORDIC_W-1:0] x_in, y_in, dx, dy;
         logic signed [ZW-1:0]       z_in;

         assign dx = y_ff[i] >>> i;
         assign dy = x_ff[i] >>> i;

         always_comb begin
            if (!z_ff[i][ZW-1]) begin
               x_in = x_ff[i] - dx;
               y_in = y_ff[i] + dy;
               z_in = z_ff[i] - signed'(DA);
            end else begin
               x_in = x_ff[i] + dx;
               y_in = y_ff[i] - dy;
               z_in = z_ff[i] + signed'(DA);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[i+1] <= 1'b0;
            end else if (adv) begin
               v_ff[i+1] <= v_ff[i];
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               bey_ff[i+1]  <= bey_ff[i];
               quad_ff[i+1] <= quad_ff[i];
               x_ff[i+1]    <= x_in;
               y_ff[i+1]    <= y_in;
               z_ff[i+1]    <= z_in;
            end
         end
      end
   endgenerate

   // stage C: quadrant fix-up and rounding to 10 fraction bits
   logic signed [CORDIC_W-1:0] qx, qy, rx_in, ry_in;
   logic                       rnd_v_ff, rnd_bey_ff;
   logic [COORD_W-1:0]         rnd_x_ff, rnd_y_ff;

   always_comb begin
      case (quad_ff[R])
         2'd1: begin
            qx = -y_ff[R];
            qy = x_ff[R];
         end
         2'd2: begin
            qx = -x_ff[R];
            qy = -y_ff[R];
         end
         2'd3: begin
            qx = y_ff[R];
            qy = -x_ff[R];
         end
         default: begin
            qx = x_ff[R];
            qy = y_ff[R];
         end
      endcase
      rx_in = (qx + CORDIC_W'(32768)) >>> 16;
      ry_in = (qy + CORDIC_W'(32768)) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_v_ff <= 1'b0;
      end else if (adv) begin
         rnd_v_ff <= v_ff[R];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rnd_bey_ff <= bey_ff[R];
         rnd_x_ff   <= rx_in[COORD_W-1:0];
         rnd_y_ff   <= ry_in[COORD_W-1:0];
      end
   end

   // pose offset and sentinel, into output register or skid stage
   logic [COORD_W-1:0] wx_in, wy_in;
   logic               out_v_ff, out_bey_ff, skid_bey_ff, out_free;
   logic [COORD_W-1:0] out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;

   assign wx_in    = rnd_bey_ff ? SENTINEL_POS : rnd_x_ff + pose_x_ff + shift_x_ff;
   assign wy_in    = rnd_bey_ff ? SENTINEL_POS : rnd_y_ff + pose_y_ff + shift_y_ff;
   assign out_free = !out_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_tready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (out_free) begin
         out_v_ff <= rnd_v_ff;
      end else if (rnd_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_tready) begin
            out_x_ff   <= skid_x_ff;
            out_y_ff   <= skid_y_ff;
            out_bey_ff <= skid_bey_ff;
         end
      end else if (out_free) begin
         out_x_ff   <= wx_in;
         out_y_ff   <= wy_in;
         out_bey_ff <= rnd_bey_ff;
      end else begin
         skid_x_ff   <= wx_in;
         skid_y_ff   <= wy_in;
         skid_bey_ff <= rnd_bey_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_y_ff, out_x_ff};
   assign rsp_tuser  = out_bey_ff;

endmodule
